>>> design/fesq_pkg.sv
`default_nettype none

package fesq_pkg;

    // Input item kinds, carried on s_tuser.
    typedef enum logic [3:0] {
        KIND_TICK         = 4'd0,
        KIND_EN_IGNITER   = 4'd1,
        KIND_DIS_IGNITER  = 4'd2,
        KIND_DIS_PILOT    = 4'd3,
        KIND_IGNITE       = 4'd4,
        KIND_EN_POOF      = 4'd5,
        KIND_DIS_POOF     = 4'd6,
        KIND_POOF         = 4'd7,
        KIND_CANCEL_POOF  = 4'd8,
        KIND_READ_CHANGED = 4'd9
    } kind_t;

    // Result message kinds, carried on m_tuser.
    localparam logic [1:0] MSG_STATUS = 2'd0;
    localparam logic [1:0] MSG_CHANGE = 2'd1;
    localparam logic [1:0] MSG_CANCEL = 2'd2;

    // Flag bit positions.
    localparam int FLAG_IGN_EN  = 0;
    localparam int FLAG_IGN_ON  = 1;
    localparam int FLAG_PIL_DLY = 2;
    localparam int FLAG_PIL_ON  = 3;
    localparam int FLAG_READY   = 4;
    localparam int FLAG_POOF_EN = 5;
    localparam int FLAG_POOF_ON = 6;
    localparam int FLAG_CHANGED = 7;

    localparam logic [31:0] ENABLE_PERIOD_MS = 32'd100;

    // Configuration register map: register i at byte address 4*i.
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_MODULE_ADDRESS = 3'd0;
    localparam logic [2:0] REG_IGNITER_CHAN   = 3'd1;
    localparam logic [2:0] REG_PILOT_CHAN     = 3'd2;
    localparam logic [2:0] REG_PILOT_PRESENT  = 3'd3;
    localparam logic [2:0] REG_MAIN_CHAN      = 3'd4;
    localparam logic [2:0] REG_IGNITE_TIME    = 3'd5;
    localparam logic [2:0] REG_PILOT_WAIT     = 3'd6;
    localparam logic [2:0] REG_POOF_LIMIT     = 3'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [15:0] module_address;
        logic [7:0]  igniter_channel;
        logic [7:0]  pilot_channel;
        logic        pilot_present;
        logic [7:0]  main_valve_channel;
        logic [31:0] ignite_time_ms;
        logic [31:0] pilot_wait_ms;
        logic [31:0] poof_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  chan;
        logic [31:0] period;
        logic        start;
        logic        stop;
    } msg_t;

    // Everything the back end needs to emit the results of one item.
    typedef struct packed {
        logic        two_msgs;
        msg_t        msg0;
        msg_t        msg1;
        logic [15:0] target_address;
        logic [7:0]  status;
        logic        changed_read;
        logic [31:0] ign_deadline;
        logic [31:0] clock_ms;
    } rec_t;

    localparam msg_t MSG_NONE = '{kind: MSG_STATUS, chan: 8'd0, period: 32'd0,
                                  start: 1'b0, stop: 1'b0};

endpackage

`default_nettype wire

>>> design/flame_effect_ignition_sequencer.sv
`default_nettype none

// Channel   | Direction | Handshake          | Contents
// ----------+-----------+--------------------+----------------------------------------------
// s_        | in        | s_tvalid/s_tready  | one command or millisecond tick per transaction
// m_        | out       | m_tvalid/m_tready  | one or two result transactions per input item
// APB       | in        | psel/penable       | eight configuration registers at 4*i
//
// The front end accepts an input transaction whenever the result queue has room and
// updates flags, clock and deadlines at that edge. Its record is written into the queue
// and then loaded into the output register, which sends one transaction per cycle while
// m_tready is high, so an item with two messages leaves as two; that register sets the rate.
// Reset (aresetn low, synchronous) clears all control state and restores the configuration.
// A stall on m_ backs up into the four-entry queue and then drops s_tready.

module flame_effect_ignition_sequencer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] burn_period, [63:32] pilot_lag
    input  wire logic [63:0]                     s_tdata,
    // [3:0] kind
    input  wire logic [3:0]                      s_tuser,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [15:0] target_address, [23:16] output_number, [55:24] change_period_ms,
    // [56] start_level, [57] stop_level, [65:58] status_bits, [66] changed_read,
    // [98:67] ignite_left_ms, [103:99] zero
    output logic [103:0]                         m_tdata,
    // [1:0] message_kind
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast,

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fesq_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    fesq_pkg::cfg_t cfg;
    fesq_pkg::rec_t front_rec;
    fesq_pkg::rec_t head;
    logic           full;
    logic           empty;
    logic           pop;
    logic           accept;

    // A transaction on the input side is taken whenever the queue can hold its record.
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    fesq_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: applies the item to the flags, clock and deadlines and builds
    // the message record that the back end will send.
    fesq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .kind_in   (s_tuser),
        .period_in (s_tdata[31:0]),
        .delay_in  (s_tdata[63:32]),
        .cfg       (cfg),
        .rec       (front_rec)
    );

    fesq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (front_rec),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    // Back end: splits each record into one or two result transactions.
    fesq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> design/fesq_cfg.sv
`default_nettype none

module fesq_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fesq_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output fesq_pkg::cfg_t                      cfg
);

    fesq_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[fesq_pkg::CFG_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.module_address     <= 16'd0;
            cfg_reg.igniter_channel    <= 8'd0;
            cfg_reg.pilot_channel      <= 8'd1;
            cfg_reg.pilot_present      <= 1'b1;
            cfg_reg.main_valve_channel <= 8'd2;
            cfg_reg.ignite_time_ms     <= 32'd5000;
            cfg_reg.pilot_wait_ms      <= 32'd1000;
            cfg_reg.poof_limit_ms      <= 32'd1000;
        end else if (wr_en) begin
            case (reg_index)
                fesq_pkg::REG_MODULE_ADDRESS: cfg_reg.module_address <= pwdata[15:0];
                fesq_pkg::REG_IGNITER_CHAN:   cfg_reg.igniter_channel <= pwdata[7:0];
                fesq_pkg::REG_PILOT_CHAN:     cfg_reg.pilot_channel <= pwdata[7:0];
                fesq_pkg::REG_PILOT_PRESENT:  cfg_reg.pilot_present <= pwdata[0];
                fesq_pkg::REG_MAIN_CHAN:      cfg_reg.main_valve_channel <= pwdata[7:0];
                fesq_pkg::REG_IGNITE_TIME:    cfg_reg.ignite_time_ms <= pwdata;
                fesq_pkg::REG_PILOT_WAIT:     cfg_reg.pilot_wait_ms <= pwdata;
                fesq_pkg::REG_POOF_LIMIT:     cfg_reg.poof_limit_ms <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            fesq_pkg::REG_MODULE_ADDRESS: prdata = {16'd0, cfg_reg.module_address};
            fesq_pkg::REG_IGNITER_CHAN:   prdata = {24'd0, cfg_reg.igniter_channel};
            fesq_pkg::REG_PILOT_CHAN:     prdata = {24'd0, cfg_reg.pilot_channel};
            fesq_pkg::REG_PILOT_PRESENT:  prdata = {31'd0, cfg_reg.pilot_present};
            fesq_pkg::REG_MAIN_CHAN:      prdata = {24'd0, cfg_reg.main_valve_channel};
            fesq_pkg::REG_IGNITE_TIME:    prdata = cfg_reg.ignite_time_ms;
            fesq_pkg::REG_PILOT_WAIT:     prdata = cfg_reg.pilot_wait_ms;
            fesq_pkg::REG_POOF_LIMIT:     prdata = cfg_reg.poof_limit_ms;
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/fesq_front.sv
`default_nettype none

module fesq_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [3:0]     kind_in,
    input  wire logic [31:0]    period_in,
    input  wire logic [31:0]    delay_in,
    input  wire fesq_pkg::cfg_t cfg,
    output fesq_pkg::rec_t      rec
);

    logic [7:0]  flag_reg, flag_next;
    logic [31:0] clock_reg, clock_next;
    logic [31:0] ign_dl_reg, ign_dl_next;
    logic [31:0] pil_dl_reg, pil_dl_next;
    logic [31:0] poof_dl_reg, poof_dl_next;

    fesq_pkg::kind_t kind;
    fesq_pkg::msg_t  msg0, msg1;
    logic            two_msgs;
    logic            chg_read;
    logic [31:0]     ig_period, ig_delay, poof_period;
    logic            clock_not_max;

    assign kind          = fesq_pkg::kind_t'(kind_in);
    assign clock_not_max = (clock_reg != 32'hFFFF_FFFF);

    // Enable igniter uses the configured periods, ignite uses the item's.
    assign ig_period   = (kind == fesq_pkg::KIND_EN_IGNITER) ? cfg.ignite_time_ms : period_in;
    assign ig_delay    = (kind == fesq_pkg::KIND_EN_IGNITER) ? cfg.pilot_wait_ms : delay_in;
    assign poof_period = (period_in > cfg.poof_limit_ms) ? cfg.poof_limit_ms : period_in;

    always_comb begin
        flag_next    = flag_reg;
        clock_next   = clock_reg;
        ign_dl_next  = ign_dl_reg;
        pil_dl_next  = pil_dl_reg;
        poof_dl_next = poof_dl_reg;
        msg0         = fesq_pkg::MSG_NONE;
        msg1         = fesq_pkg::MSG_NONE;
        two_msgs     = 1'b0;
        chg_read     = 1'b0;

        case (kind)
            fesq_pkg::KIND_TICK: begin
                clock_next = clock_reg + 32'd1;
                // clock+1 > deadline, where a wrap to zero never passes.
                if (flag_reg[fesq_pkg::FLAG_IGN_ON] && clock_not_max
                        && clock_reg >= ign_dl_reg) begin
                    flag_next[fesq_pkg::FLAG_IGN_ON]  = 1'b0;
                    flag_next[fesq_pkg::FLAG_READY]   = 1'b1;
                    flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
                    ign_dl_next = 32'd0;
                end
                if (flag_reg[fesq_pkg::FLAG_PIL_DLY] && clock_not_max
                        && clock_reg >= pil_dl_reg) begin
                    flag_next[fesq_pkg::FLAG_PIL_DLY] = 1'b0;
                    flag_next[fesq_pkg::FLAG_PIL_ON]  = 1'b1;
                    flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
                    pil_dl_next = 32'd0;
                end
                if (flag_reg[fesq_pkg::FLAG_POOF_ON] && clock_not_max
                        && clock_reg >= poof_dl_reg) begin
                    flag_next[fesq_pkg::FLAG_POOF_ON] = 1'b0;
                    flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
                    poof_dl_next = 32'd0;
                end
            end
            fesq_pkg::KIND_EN_IGNITER, fesq_pkg::KIND_IGNITE: begin
                if (kind == fesq_pkg::KIND_EN_IGNITER) begin
                    flag_next[fesq_pkg::FLAG_IGN_EN]  = 1'b1;
                    flag_next[fesq_pkg::FLAG_READY]   = 1'b0;
                    flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
                end
                if (flag_next[fesq_pkg::FLAG_IGN_EN]) begin
                    flag_next[fesq_pkg::FLAG_IGN_ON] = 1'b1;
                    ign_dl_next = clock_reg + ig_period;
                    msg0 = '{kind: fesq_pkg::MSG_CHANGE, chan: cfg.igniter_channel,
                             period: ig_period, start: 1'b1, stop: 1'b0};
                    if (cfg.pilot_present) begin
                        flag_next[fesq_pkg::FLAG_PIL_DLY] = 1'b1;
                        pil_dl_next = clock_reg + ig_delay;
                        msg1 = '{kind: fesq_pkg::MSG_CHANGE, chan: cfg.pilot_channel,
                                 period: ig_delay, start: 1'b0, stop: 1'b1};
                        two_msgs = 1'b1;
                    end
                end
            end
            fesq_pkg::KIND_DIS_IGNITER: begin
                flag_next[fesq_pkg::FLAG_IGN_EN]  = 1'b0;
                flag_next[fesq_pkg::FLAG_IGN_ON]  = 1'b0;
                flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
                msg0 = '{kind: fesq_pkg::MSG_CHANGE, chan: cfg.igniter_channel,
                         period: fesq_pkg::ENABLE_PERIOD_MS, start: 1'b0, stop: 1'b0};
            end
            fesq_pkg::KIND_DIS_PILOT: begin
                if (cfg.pilot_present) begin
                    flag_next[fesq_pkg::FLAG_READY]   = 1'b0;
                    flag_next[fesq_pkg::FLAG_POOF_EN] = 1'b0;
                    flag_next[fesq_pkg::FLAG_POOF_ON] = 1'b0;
                    flag_next[fesq_pkg::FLAG_PIL_DLY] = 1'b0;
                    flag_next[fesq_pkg::FLAG_PIL_ON]  = 1'b0;
                    flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
                    msg0 = '{kind: fesq_pkg::MSG_CHANGE, chan: cfg.main_valve_channel,
                             period: fesq_pkg::ENABLE_PERIOD_MS, start: 1'b0, stop: 1'b0};
                    msg1 = '{kind: fesq_pkg::MSG_CHANGE, chan: cfg.pilot_channel,
                             period: fesq_pkg::ENABLE_PERIOD_MS, start: 1'b0, stop: 1'b0};
                    two_msgs = 1'b1;
                end
            end
            fesq_pkg::KIND_EN_POOF: begin
                flag_next[fesq_pkg::FLAG_POOF_EN] = 1'b1;
                flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
            end
            fesq_pkg::KIND_DIS_POOF: begin
                flag_next[fesq_pkg::FLAG_POOF_EN] = 1'b0;
                flag_next[fesq_pkg::FLAG_POOF_ON] = 1'b0;
                flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
                msg0 = '{kind: fesq_pkg::MSG_CHANGE, chan: cfg.main_valve_channel,
                         period: fesq_pkg::ENABLE_PERIOD_MS, start: 1'b0, stop: 1'b0};
            end
            fesq_pkg::KIND_POOF: begin
                if (flag_reg[fesq_pkg::FLAG_READY] && flag_reg[fesq_pkg::FLAG_POOF_EN]) begin
                    if (!flag_reg[fesq_pkg::FLAG_POOF_ON]) begin
                        flag_next[fesq_pkg::FLAG_CHANGED] = 1'b1;
                    end
                    flag_next[fesq_pkg::FLAG_POOF_ON] = 1'b1;
                    poof_dl_next = clock_reg + poof_period;
                    msg0 = '{kind: fesq_pkg::MSG_CHANGE, chan: cfg.main_valve_channel,
                             period: poof_period, start: 1'b1, stop: 1'b0};
                end
            end
            fesq_pkg::KIND_CANCEL_POOF: begin
                flag_next[fesq_pkg::FLAG_POOF_ON] = 1'b0;
                msg0 = '{kind: fesq_pkg::MSG_CANCEL, chan: cfg.main_valve_channel,
                         period: 32'd0, start: 1'b0, stop: 1'b0};
            end
            fesq_pkg::KIND_READ_CHANGED: begin
                chg_read = flag_reg[fesq_pkg::FLAG_CHANGED];
                flag_next[fesq_pkg::FLAG_CHANGED] = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg    <= 8'd0;
            clock_reg   <= 32'd0;
            ign_dl_reg  <= 32'd0;
            pil_dl_reg  <= 32'd0;
            poof_dl_reg <= 32'd0;
        end else if (accept) begin
            flag_reg    <= flag_next;
            clock_reg   <= clock_next;
            ign_dl_reg  <= ign_dl_next;
            pil_dl_reg  <= pil_dl_next;
            poof_dl_reg <= poof_dl_next;
        end
    end

    always_comb begin
        rec.two_msgs       = two_msgs;
        rec.msg0           = msg0;
        rec.msg1           = msg1;
        rec.target_address = cfg.module_address;
        rec.status         = flag_next;
        rec.changed_read   = chg_read;
        rec.ign_deadline   = ign_dl_next;
        rec.clock_ms       = clock_next;
    end

endmodule

`default_nettype wire

>>> design/fesq_queue.sv
`default_nettype none

module fesq_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire fesq_pkg::rec_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output fesq_pkg::rec_t      head
);

    fesq_pkg::rec_t                     entry_reg [fesq_pkg::QUEUE_DEPTH];
    logic [fesq_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [fesq_pkg::QUEUE_PTR_W:0]     count_reg, count_next;

    assign full  = (count_reg == (fesq_pkg::QUEUE_PTR_W + 1)'(fesq_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> design/fesq_back.sv
`default_nettype none

module fesq_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           empty,
    input  wire fesq_pkg::rec_t head,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [103:0]        m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);

    logic           valid_reg;
    logic           second_reg, second_next;
    logic [103:0]   data_reg;
    logic [1:0]     user_reg;
    logic           last_reg;

    logic           load;
    logic           is_last;
    fesq_pkg::msg_t msg;
    logic [31:0]    left;

    assign load    = (!valid_reg || m_tready) && !empty;
    assign is_last = second_reg || !head.two_msgs;
    assign pop     = load && is_last;
    assign msg     = second_reg ? head.msg1 : head.msg0;
    assign left    = (head.ign_deadline == 32'd0) ? 32'd0
                                                  : head.ign_deadline - head.clock_ms;

    always_comb begin
        second_next = second_reg;
        if (load) begin
            second_next = !is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            second_reg <= second_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {5'd0, left, head.changed_read, head.status, msg.stop, msg.start,
                         msg.period, msg.chan, head.target_address};
            user_reg <= msg.kind;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire
